[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/dmt_pkg.sv]
// ----------------------------------------------------------------------------
// Depth map triangulation package
// Field widths, register map codes, record kinds and the triangle type.
// ----------------------------------------------------------------------------
package dmt_pkg;

    localparam int DEPTH_W  = 16;
    localparam int INDEX_W  = 32;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int FW_W     = 11;
    localparam int FH_W     = 13;
    localparam int CUT_W    = 17;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int MAX_ROWS = 4096;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CUT_LEVEL    = 2'd2;
    localparam logic [1:0] REG_BASE_INDEX   = 2'd3;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef struct packed {
        logic [INDEX_W-1:0] first;
        logic [INDEX_W-1:0] second;
        logic [INDEX_W-1:0] third;
    } t_tri;

endpackage

[src/depth_map_triangulation.sv]
// ----------------------------------------------------------------------------
// Depth map triangulation
// Turns a raster stream of depth pixels into vertex records and up to two
// grid triangles per pixel, using a line store for the previous row.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Content
//  input     in         i_in_valid / o_in_ready   one depth pixel
//  output    out        o_out_valid / i_out_ready vertex or triangle record
//  config    in         APB psel/penable/pready   four registers
//
//  A pixel yields its vertex record and then up to two triangle records;
//  the single output port takes one record per cycle while i_out_ready
//  is high. The first record of a pixel is presented by the emit stage
//  after the pixel has passed the read stage. Reset is synchronous and
//  clears counters, window state and configuration; the line store is
//  not cleared. A stall on the output backs up through the emitter and
//  the read stage to o_in_ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_map_triangulation #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dmt_pkg::ADDR_W-1:0]    paddr,
    input  logic [dmt_pkg::DATA_W-1:0]    pwdata,
    output logic [dmt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dmt_pkg::DEPTH_W-1:0]   i_depth_sample,
    // Record output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_record_kind,
    output logic [dmt_pkg::INDEX_W-1:0]   o_index_first,
    output logic [dmt_pkg::INDEX_W-1:0]   o_index_second,
    output logic [dmt_pkg::INDEX_W-1:0]   o_index_third,
    output logic [dmt_pkg::COL_W-1:0]     o_pixel_col,
    output logic [dmt_pkg::ROW_W-1:0]     o_pixel_row,
    output logic [dmt_pkg::DEPTH_W-1:0]   o_depth_out,
    output logic                          o_last_of_run
);
    import dmt_pkg::*;

    localparam int AW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WREQ  = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (WREQ > FW_W) ? WREQ : FW_W;

    // Configuration registers
    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [CUT_W-1:0]   r_cut_level;
    logic [INDEX_W-1:0] r_base_index;

    // Raster position and running index
    logic [AW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;
    logic [INDEX_W-1:0] r_vcount;
    logic [AW-1:0]      n_col;
    logic [ROW_W-1:0]   n_row;

    // Line store and its registered read port
    logic [DEPTH_W-1:0] r_row_mem [MAX_WIDTH];
    logic [DEPTH_W-1:0] r_up;

    // Read stage
    logic               r_a_valid;
    logic [DEPTH_W-1:0] r_a_depth;
    logic [AW-1:0]      r_a_col;
    logic [ROW_W-1:0]   r_a_row;
    logic [INDEX_W-1:0] r_a_idx;
    logic [INDEX_W-1:0] r_a_b;
    logic [INDEX_W-1:0] r_a_l;
    logic               r_a_inner;

    // Window state
    logic [DEPTH_W-1:0] r_ul;
    logic [DEPTH_W-1:0] r_left;

    // Emit stage
    logic               r_e_valid;
    logic [1:0]         r_e_step;
    logic [1:0]         r_e_ntri;
    logic [INDEX_W-1:0] r_e_idx;
    t_tri               r_e_tri0;
    t_tri               r_e_tri1;
    logic [AW-1:0]      r_e_col;
    logic [ROW_W-1:0]   r_e_row;
    logic [DEPTH_W-1:0] r_e_depth;

    logic               in_xfer;
    logic               out_xfer;
    logic               e_last;
    logic               e_free;
    logic               a_to_e;
    logic               cfg_wr;

    logic [WW-1:0]      fw_ext;
    logic [WW-1:0]      w_sat;
    logic [WW-1:0]      col_p1;
    logic [FH_W-1:0]    h_sat;
    logic [FH_W-1:0]    row_p1;
    logic [INDEX_W-1:0] cur_idx;

    logic [DEPTH_W-1:0] diff_c_ul;
    logic [DEPTH_W-1:0] diff_l_u;
    logic               cul, cu, cl, cc;
    logic [INDEX_W-1:0] idx_a;
    t_tri               tri_one;
    t_tri               tri_two;
    logic               en_one;
    logic               en_two;
    t_tri               out_tri;
    logic [INDEX_W-1:0] col_ext;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(640);
            r_frame_height <= FH_W'(480);
            r_cut_level    <= CUT_W'(65535);
            r_base_index   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                REG_CUT_LEVEL:    r_cut_level    <= pwdata[CUT_W-1:0];
                REG_BASE_INDEX:   r_base_index   <= pwdata[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_height);
            REG_CUT_LEVEL:    prdata = DATA_W'(r_cut_level);
            REG_BASE_INDEX:   prdata = r_base_index;
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign e_last     = (r_e_step == r_e_ntri);
    assign out_xfer   = o_out_valid && i_out_ready;
    assign e_free     = !r_e_valid || (out_xfer && e_last);
    assign a_to_e     = r_a_valid && e_free;
    assign o_in_ready = !r_a_valid || e_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Raster counters
    // ------------------------------------------------------------------
    always_comb begin
        fw_ext = WW'(r_frame_width);
        if (fw_ext < WW'(2)) begin
            w_sat = WW'(2);
        end else if (fw_ext > WW'(MAX_WIDTH)) begin
            w_sat = WW'(MAX_WIDTH);
        end else begin
            w_sat = fw_ext;
        end

        if (r_frame_height == '0) begin
            h_sat = FH_W'(1);
        end else if (r_frame_height > FH_W'(MAX_ROWS)) begin
            h_sat = FH_W'(MAX_ROWS);
        end else begin
            h_sat = r_frame_height;
        end

        col_p1 = WW'(r_col) + WW'(1);
        row_p1 = FH_W'(r_row) + FH_W'(1);
        n_col  = r_col;
        n_row  = r_row;
        // A count that reaches or passes the current geometry ends the row.
        if (col_p1 >= w_sat) begin
            n_col = '0;
            n_row = (row_p1 >= h_sat) ? '0 : row_p1[ROW_W-1:0];
        end else begin
            n_col = col_p1[AW-1:0];
        end

        cur_idx = (r_col == '0 && r_row == '0) ? r_base_index : r_vcount;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_vcount <= '0;
        end else if (in_xfer) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_vcount <= cur_idx + INDEX_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Line store: read-first, so the old entry comes out as the pixel above
    // while the new pixel overwrites it in the same cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_up           <= r_row_mem[r_col];
            r_row_mem[r_col] <= i_depth_sample;
        end
    end

    // ------------------------------------------------------------------
    // Read stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_xfer) begin
            r_a_valid <= 1'b1;
        end else if (a_to_e) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_depth <= i_depth_sample;
            r_a_col   <= r_col;
            r_a_row   <= r_row;
            r_a_idx   <= cur_idx;
            r_a_b     <= cur_idx - INDEX_W'(w_sat);
            r_a_l     <= cur_idx - INDEX_W'(1);
            r_a_inner <= (r_col != '0) && (r_row != '0);
        end
    end

    // ------------------------------------------------------------------
    // Window decision and triangle selection
    // ------------------------------------------------------------------
    always_comb begin
        diff_c_ul = (r_a_depth > r_ul) ? (r_a_depth - r_ul) : (r_ul - r_a_depth);
        diff_l_u  = (r_left > r_up) ? (r_left - r_up) : (r_up - r_left);
        cul = CUT_W'(r_ul) < r_cut_level;
        cu  = CUT_W'(r_up) < r_cut_level;
        cl  = CUT_W'(r_left) < r_cut_level;
        cc  = CUT_W'(r_a_depth) < r_cut_level;
        idx_a = r_a_b - INDEX_W'(1);

        if (diff_c_ul > diff_l_u) begin
            // Split along the upper / left diagonal.
            tri_one = '{first: idx_a, second: r_a_b, third: r_a_l};
            tri_two = '{first: r_a_b, second: r_a_idx, third: r_a_l};
            en_one  = cul && cl && cu;
            en_two  = cu && cl && cc;
        end else begin
            // Split along the upper-left / current diagonal.
            tri_one = '{first: idx_a, second: r_a_idx, third: r_a_l};
            tri_two = '{first: r_a_idx, second: idx_a, third: r_a_b};
            en_one  = cul && cl && cc;
            en_two  = cul && cu && cc;
        end
        en_one = en_one && r_a_inner;
        en_two = en_two && r_a_inner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul   <= '0;
            r_left <= '0;
        end else if (a_to_e) begin
            r_ul   <= r_up;
            r_left <= r_a_depth;
        end
    end

    // ------------------------------------------------------------------
    // Emit stage: one record per transfer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_step  <= '0;
            r_e_ntri  <= '0;
        end else if (e_free) begin
            r_e_valid <= a_to_e;
            r_e_step  <= '0;
            r_e_ntri  <= a_to_e ? 2'(en_one) + 2'(en_two) : 2'd0;
        end else if (out_xfer) begin
            r_e_step  <= r_e_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_to_e) begin
            r_e_idx   <= r_a_idx;
            r_e_tri0  <= en_one ? tri_one : tri_two;
            r_e_tri1  <= tri_two;
            r_e_col   <= r_a_col;
            r_e_row   <= r_a_row;
            r_e_depth <= r_a_depth;
        end
    end

    always_comb begin
        out_tri = (r_e_step == 2'd2) ? r_e_tri1 : r_e_tri0;
        col_ext = INDEX_W'(r_e_col);
        if (r_e_step == '0) begin
            o_record_kind  = KIND_VERTEX;
            o_index_first  = r_e_idx;
            o_index_second = '0;
            o_index_third  = '0;
        end else begin
            o_record_kind  = KIND_TRIANGLE;
            o_index_first  = out_tri.first;
            o_index_second = out_tri.second;
            o_index_third  = out_tri.third;
        end
    end

    assign o_out_valid   = r_e_valid;
    assign o_pixel_col   = col_ext[COL_W-1:0];
    assign o_pixel_row   = r_e_row;
    assign o_depth_out   = r_e_depth;
    assign o_last_of_run = e_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_SAME(a_step_range, i_clk, i_rst_n, r_e_valid, r_e_step <= r_e_ntri, "emit step past triangle count")
    `ASSERT_NEXT(a_step_adv, i_clk, i_rst_n, out_xfer && !e_last, o_out_valid && r_e_step == $past(r_e_step) + 2'd1, "emitter did not advance")
    `ASSERT_NEXT(a_drain, i_clk, i_rst_n, out_xfer && e_last && !r_a_valid, !o_out_valid, "record repeated after last transfer")
    `ASSERT_SAME(a_hold_a, i_clk, i_rst_n, r_a_valid && !e_free, !o_in_ready, "read stage overwritten while held")
    `ASSERT_ALWAYS(a_ntri_max, i_clk, i_rst_n, r_e_ntri != 2'd3, "more than two triangles")

endmodule
